[sv/nccl_pkg.sv]
`timescale 1ns / 1ps
package nccl_pkg;

  localparam int unsigned CFG_W         = 5;
  localparam int unsigned SLOT_W        = 4;
  localparam int unsigned LABEL_W       = 4;
  localparam int unsigned LABEL_SLOTS   = 16;
  localparam int unsigned COMP_W        = 16;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned UNIT_W        = 16;
  localparam int unsigned PROD_W        = 24;
  localparam int unsigned DOT_W         = 25;
  localparam int unsigned Q15_ONE       = 32768;
  localparam int unsigned MAX_CENT_DEF  = 16;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef logic [UNIT_W-1:0] unit_t;

  // one write into the unit centroid store
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
    unit_t             ur;
    unit_t             ug;
    unit_t             ub;
  } unit_wr_t;

endpackage

[sv/nccl_norm.sv]
`timescale 1ns / 1ps
module nccl_norm (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [nccl_pkg::SLOT_W-1:0]    slot_i,
  input  logic [nccl_pkg::COMP_W-1:0]    red_i,
  input  logic [nccl_pkg::COMP_W-1:0]    green_i,
  input  logic [nccl_pkg::COMP_W-1:0]    blue_i,
  output logic                           busy_o,
  output nccl_pkg::unit_wr_t             wr_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_SUM, S_ROOT, S_PREP, S_DIV, S_WRITE
  } state_e;

  state_e                          state_q, state_d;
  logic [nccl_pkg::SLOT_W-1:0]     slot_q, slot_d;
  logic [nccl_pkg::COMP_W-1:0]     comp_q [3];
  logic [nccl_pkg::COMP_W-1:0]     comp_d [3];
  logic [31:0]                     sq_q [3];
  logic [31:0]                     sq_d [3];
  logic [33:0]                     sum_q, sum_d;
  logic [19:0]                     rem_q, rem_d;
  logic [16:0]                     root_q, root_d;
  logic [4:0]                      cnt_q, cnt_d;
  logic [31:0]                     num_q [3];
  logic [31:0]                     num_d [3];
  logic [16:0]                     drem_q [3];
  logic [16:0]                     drem_d [3];
  logic [31:0]                     quo_q [3];
  logic [31:0]                     quo_d [3];
  nccl_pkg::unit_wr_t              wr_q, wr_d;
  nccl_pkg::unit_t                 unit_v [3];

  always_comb begin
    logic [19:0] rm;
    logic [19:0] trial;
    logic [17:0] tr;
    state_d = state_q;
    slot_d  = slot_q;
    comp_d  = comp_q;
    sq_d    = sq_q;
    sum_d   = sum_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    drem_d  = drem_q;
    quo_d   = quo_q;
    wr_d    = wr_q;
    wr_d.we = 1'b0;
    rm      = '0;
    trial   = '0;
    tr      = '0;
    for (int i = 0; i < 3; i++) begin
      if (root_q == '0) begin
        unit_v[i] = '0;
      end else if (quo_q[i] > 32'(nccl_pkg::Q15_ONE)) begin
        unit_v[i] = nccl_pkg::UNIT_W'(nccl_pkg::Q15_ONE);
      end else begin
        unit_v[i] = quo_q[i][nccl_pkg::UNIT_W-1:0];
      end
    end
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          comp_d[0] = red_i;
          comp_d[1] = green_i;
          comp_d[2] = blue_i;
          slot_d    = slot_i;
          state_d   = S_SQ;
        end
      end
      S_SQ: begin
        for (int i = 0; i < 3; i++) begin
          sq_d[i] = {16'b0, comp_q[i]} * {16'b0, comp_q[i]};
        end
        state_d = S_SUM;
      end
      S_SUM: begin
        sum_d   = 34'(sq_q[0]) + 34'(sq_q[1]) + 34'(sq_q[2]);
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = 5'd16;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        // one root bit a cycle, two radicand bits in
        rm    = {rem_q[17:0], sum_q[33:32]};
        trial = {1'b0, root_q, 2'b01};
        if (rm >= trial) begin
          rem_d  = rm - trial;
          root_d = {root_q[15:0], 1'b1};
        end else begin
          rem_d  = rm;
          root_d = {root_q[15:0], 1'b0};
        end
        sum_d = {sum_q[31:0], 2'b00};
        if (cnt_q == '0) begin
          state_d = S_PREP;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      S_PREP: begin
        for (int i = 0; i < 3; i++) begin
          num_d[i]  = {1'b0, comp_q[i], 15'b0} + {16'b0, root_q[16:1]};
          drem_d[i] = '0;
          quo_d[i]  = '0;
        end
        cnt_d   = 5'd31;
        state_d = S_DIV;
      end
      S_DIV: begin
        // restoring division, one quotient bit a cycle per component
        for (int i = 0; i < 3; i++) begin
          tr = {drem_q[i], num_q[i][31]};
          if (tr >= {1'b0, root_q}) begin
            drem_d[i] = 17'(tr - {1'b0, root_q});
            quo_d[i]  = {quo_q[i][30:0], 1'b1};
          end else begin
            drem_d[i] = tr[16:0];
            quo_d[i]  = {quo_q[i][30:0], 1'b0};
          end
          num_d[i] = {num_q[i][30:0], 1'b0};
        end
        if (cnt_q == '0) begin
          state_d = S_WRITE;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      S_WRITE: begin
        wr_d.we   = 1'b1;
        wr_d.slot = slot_q;
        wr_d.ur   = unit_v[0];
        wr_d.ug   = unit_v[1];
        wr_d.ub   = unit_v[2];
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wr_q    <= '0;
      slot_q  <= '0;
      comp_q  <= '{default: '0};
      sq_q    <= '{default: '0};
      sum_q   <= '0;
      rem_q   <= '0;
      root_q  <= '0;
      cnt_q   <= '0;
      num_q   <= '{default: '0};
      drem_q  <= '{default: '0};
      quo_q   <= '{default: '0};
    end else begin
      state_q <= state_d;
      wr_q    <= wr_d;
      slot_q  <= slot_d;
      comp_q  <= comp_d;
      sq_q    <= sq_d;
      sum_q   <= sum_d;
      rem_q   <= rem_d;
      root_q  <= root_d;
      cnt_q   <= cnt_d;
      num_q   <= num_d;
      drem_q  <= drem_d;
      quo_q   <= quo_d;
    end
  end

  // hold busy through the store write so no pixel reads a stale slot
  assign busy_o = (state_q != S_IDLE) || wr_q.we;
  assign wr_o   = wr_q;

endmodule

[sv/nccl_argmax.sv]
`timescale 1ns / 1ps
module nccl_argmax #(
  parameter int unsigned LANES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic                          live_i [LANES],
  input  logic [nccl_pkg::DOT_W-1:0]    dot_i  [LANES],
  output logic                          valid_o,
  output logic [nccl_pkg::LABEL_W-1:0]  label_o,
  output logic [nccl_pkg::DOT_W-1:0]    dot_o
);

  localparam int unsigned LEVELS = $clog2(LANES);
  localparam int unsigned P      = 1 << LEVELS;

  logic                          vld_q  [LEVELS];
  logic                          live_q [LEVELS][P];
  logic [nccl_pkg::LABEL_W-1:0]  lab_q  [LEVELS][P];
  logic [nccl_pkg::DOT_W-1:0]    dot_q  [LEVELS][P];

  logic                          src_vld  [LEVELS];
  logic                          src_live [LEVELS][P];
  logic [nccl_pkg::LABEL_W-1:0]  src_lab  [LEVELS][P];
  logic [nccl_pkg::DOT_W-1:0]    src_dot  [LEVELS][P];

  logic                          nx_live [LEVELS][P];
  logic [nccl_pkg::LABEL_W-1:0]  nx_lab  [LEVELS][P];
  logic [nccl_pkg::DOT_W-1:0]    nx_dot  [LEVELS][P];

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    if (l == 0) begin : g_first
      assign src_vld[l] = valid_i;
      for (genvar j = 0; j < P; j++) begin : g_pad
        if (j < LANES) begin : g_in
          assign src_live[l][j] = live_i[j];
          assign src_dot[l][j]  = dot_i[j];
        end else begin : g_fill
          assign src_live[l][j] = 1'b0;
          assign src_dot[l][j]  = '0;
        end
        assign src_lab[l][j] = nccl_pkg::LABEL_W'(j);
      end
    end else begin : g_next
      assign src_vld[l]  = vld_q[l-1];
      assign src_live[l] = live_q[l-1];
      assign src_lab[l]  = lab_q[l-1];
      assign src_dot[l]  = dot_q[l-1];
    end

    // pairwise pick; the right side wins only when live and either strictly greater or the left is dead
    always_comb begin
      int unsigned a;
      int unsigned b;
      for (int unsigned j = 0; j < P; j++) begin
        a = 2 * j;
        b = 2 * j + 1;
        if (b >= P) begin
          a = 0;
          b = 0;
        end
        if (src_live[l][b] && (!src_live[l][a] || src_dot[l][b] > src_dot[l][a])) begin
          nx_live[l][j] = 1'b1;
          nx_lab[l][j]  = src_lab[l][b];
          nx_dot[l][j]  = src_dot[l][b];
        end else begin
          nx_live[l][j] = src_live[l][a];
          nx_lab[l][j]  = src_lab[l][a];
          nx_dot[l][j]  = src_dot[l][a];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[l] <= 1'b0;
      end else if (en_i) begin
        vld_q[l] <= src_vld[l];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        live_q[l] <= nx_live[l];
        lab_q[l]  <= nx_lab[l];
        dot_q[l]  <= nx_dot[l];
      end
    end
  end

  assign valid_o = vld_q[LEVELS-1];
  assign label_o = lab_q[LEVELS-1][0];
  assign dot_o   = dot_q[LEVELS-1][0];

endmodule

[sv/nearest_chroma_classifier_unit.sv]
`timescale 1ns / 1ps
// Nearest colour-direction classifier. A pixel word (cmd high) is labelled with
// the stored centroid whose unit vector gives the largest dot product, ties to
// the lower index, and returns that dot product in Q10.15 scale. Pixel words
// flow through 2 + clog2(min(MAX_CENTROIDS,16)) register stages (6 at the
// default) and one may enter every cycle unless the output word is held; all
// centroid lanes are multiplied in parallel and reduced by a registered
// compare tree. A load word (cmd low) normalises its colour in a shared
// serial unit: squares, an integer square root, a divider and the store
// write, during which the input is stalled. A load produces no output word.
// Write num_centroids only while the block is idle.
module nearest_chroma_classifier_unit #(
  parameter int unsigned MAX_CENTROIDS = nccl_pkg::MAX_CENT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nccl_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           valid_i,
  output logic                           stall_o,
  input  logic                           cmd_i,
  input  logic [nccl_pkg::SLOT_W-1:0]    slot_i,
  input  logic [nccl_pkg::COMP_W-1:0]    centroid_red_i,
  input  logic [nccl_pkg::COMP_W-1:0]    centroid_green_i,
  input  logic [nccl_pkg::COMP_W-1:0]    centroid_blue_i,
  input  logic [nccl_pkg::PIX_W-1:0]     pixel_red_i,
  input  logic [nccl_pkg::PIX_W-1:0]     pixel_green_i,
  input  logic [nccl_pkg::PIX_W-1:0]     pixel_blue_i,
  output logic                           valid_o,
  input  logic                           stall_i,
  output logic [nccl_pkg::LABEL_W-1:0]   label_o,
  output logic [nccl_pkg::DOT_W-1:0]     similarity_o
);

  // labels are four bits wide, so never search more than sixteen lanes
  localparam int unsigned LANES  = (MAX_CENTROIDS < nccl_pkg::LABEL_SLOTS) ?
                                   MAX_CENTROIDS : nccl_pkg::LABEL_SLOTS;
  localparam int unsigned LANE_W = $clog2(LANES);

  logic [nccl_pkg::CFG_W-1:0]   cfg_q;
  logic [nccl_pkg::CFG_W-1:0]   count;
  logic                         en;
  logic                         accept;
  logic                         load_busy;
  nccl_pkg::unit_wr_t           wr;

  // unit centroid store, undefined until loaded
  nccl_pkg::unit_t              ur_q [LANES];
  nccl_pkg::unit_t              ug_q [LANES];
  nccl_pkg::unit_t              ub_q [LANES];

  logic                         v1_q, v2_q;
  logic                         live1_q [LANES];
  logic                         live2_q [LANES];
  logic [nccl_pkg::PROD_W-1:0]  pr_q [LANES];
  logic [nccl_pkg::PROD_W-1:0]  pg_q [LANES];
  logic [nccl_pkg::PROD_W-1:0]  pb_q [LANES];
  logic [nccl_pkg::DOT_W-1:0]   dot2_q [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= nccl_pkg::CFG_W'(1);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // zero searches one slot; saturate to the lane count
  always_comb begin
    if (cfg_q == '0) begin
      count = nccl_pkg::CFG_W'(1);
    end else if (cfg_q > nccl_pkg::CFG_W'(LANES)) begin
      count = nccl_pkg::CFG_W'(LANES);
    end else begin
      count = cfg_q;
    end
  end

  // advance the whole pipe unless the output word is held
  assign en      = !(valid_o && stall_i);
  assign stall_o = load_busy || !en;
  assign accept  = valid_i && !stall_o;

  nccl_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && (cmd_i == nccl_pkg::CMD_LOAD)),
    .slot_i  (slot_i),
    .red_i   (centroid_red_i),
    .green_i (centroid_green_i),
    .blue_i  (centroid_blue_i),
    .busy_o  (load_busy),
    .wr_o    (wr)
  );

  // drop loads aimed past the store
  always_ff @(posedge clk_i) begin
    if (wr.we && ({1'b0, wr.slot} < (nccl_pkg::SLOT_W + 1)'(LANES))) begin
      ur_q[wr.slot[LANE_W-1:0]] <= wr.ur;
      ug_q[wr.slot[LANE_W-1:0]] <= wr.ug;
      ub_q[wr.slot[LANE_W-1:0]] <= wr.ub;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept && (cmd_i == nccl_pkg::CMD_PIXEL);
      v2_q <= v1_q;
    end
  end

  // stage one: per-lane products taken straight from the accepted word
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int unsigned k = 0; k < LANES; k++) begin
        pr_q[k]    <= {16'b0, pixel_red_i}   * {8'b0, ur_q[k]};
        pg_q[k]    <= {16'b0, pixel_green_i} * {8'b0, ug_q[k]};
        pb_q[k]    <= {16'b0, pixel_blue_i}  * {8'b0, ub_q[k]};
        live1_q[k] <= (nccl_pkg::CFG_W'(k) < count);
      end
    end
  end

  // stage two: lane sums
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int unsigned k = 0; k < LANES; k++) begin
        dot2_q[k]  <= nccl_pkg::DOT_W'(pr_q[k]) + nccl_pkg::DOT_W'(pg_q[k])
                    + nccl_pkg::DOT_W'(pb_q[k]);
        live2_q[k] <= live1_q[k];
      end
    end
  end

  nccl_argmax #(
    .LANES (LANES)
  ) u_argmax (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .live_i  (live2_q),
    .dot_i   (dot2_q),
    .valid_o (valid_o),
    .label_o (label_o),
    .dot_o   (similarity_o)
  );

  a_busy_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_busy |-> stall_o)
    else $error("input taken while a load is normalising");

  a_load_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == nccl_pkg::CMD_LOAD)) |=> load_busy)
    else $error("accepted load did not start the normaliser");

  a_label_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ({1'b0, label_o} < count))
    else $error("label beyond the searched centroids");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
module testbench;

  // The driver sends load words (cmd low), which normalise a mean colour into a
  // centroid slot, and pixel words (cmd high), which return the label of the
  // nearest centroid direction and its dot product. A local predictor keeps its
  // own copy of the unit centroids and of num_centroids. It works out the answer
  // for every accepted pixel word and queues it. The checker compares each
  // accepted output word with the oldest queued answer.
  //
  // The sender runs in bursts with random gaps. The receiver stalls on a pattern
  // that rotates through no stall, light random, periodic and heavy random.
  // num_centroids is rewritten only once the block is idle. Load words produce no
  // output, so a write waits out the normalisation time after the queue drains.

  localparam int unsigned NUM_SLOTS  = 16;
  localparam int unsigned LOAD_SETTLE = 80;  // outlasts the serial normaliser's stall
  localparam int unsigned TAIL_CYCLES = 20;  // pixel pipe is 6 stages deep

  typedef struct {
    logic [nccl_pkg::LABEL_W-1:0] label;
    logic [nccl_pkg::DOT_W-1:0]   similarity;
  } match_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [nccl_pkg::CFG_W-1:0]    cfg_data_i;
  logic                          valid_i;
  logic                          stall_o;
  logic                          cmd_i;
  logic [nccl_pkg::SLOT_W-1:0]   slot_i;
  logic [nccl_pkg::COMP_W-1:0]   centroid_red_i;
  logic [nccl_pkg::COMP_W-1:0]   centroid_green_i;
  logic [nccl_pkg::COMP_W-1:0]   centroid_blue_i;
  logic [nccl_pkg::PIX_W-1:0]    pixel_red_i;
  logic [nccl_pkg::PIX_W-1:0]    pixel_green_i;
  logic [nccl_pkg::PIX_W-1:0]    pixel_blue_i;
  logic                          valid_o;
  logic                          stall_i;
  logic [nccl_pkg::LABEL_W-1:0]  label_o;
  logic [nccl_pkg::DOT_W-1:0]    similarity_o;

  // predictor state
  nccl_pkg::unit_t            unit_red   [NUM_SLOTS];
  nccl_pkg::unit_t            unit_green [NUM_SLOTS];
  nccl_pkg::unit_t            unit_blue  [NUM_SLOTS];
  logic [nccl_pkg::CFG_W-1:0] search_count;
  match_t                     pending_matches[$];

  int unsigned errors;
  int unsigned pixels_sent;
  int unsigned loads_sent;
  int unsigned labels_checked;
  int unsigned burst_left;
  int unsigned stall_cycle;

  nearest_chroma_classifier_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .cmd_i           (cmd_i),
    .slot_i          (slot_i),
    .centroid_red_i  (centroid_red_i),
    .centroid_green_i(centroid_green_i),
    .centroid_blue_i (centroid_blue_i),
    .pixel_red_i     (pixel_red_i),
    .pixel_green_i   (pixel_green_i),
    .pixel_blue_i    (pixel_blue_i),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .label_o         (label_o),
    .similarity_o    (similarity_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Exact floor square root, bit by bit.
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned bitpos;
    root   = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > v) bitpos >>= 2;
    while (bitpos != 0) begin
      if (v >= root + bitpos) begin
        v    = v - (root + bitpos);
        root = (root >> 1) + bitpos;
      end else begin
        root >>= 1;
      end
      bitpos >>= 2;
    end
    return root;
  endfunction

  // Scale one component to Q1.15 against the colour's length, rounded.
  function automatic nccl_pkg::unit_t to_unit(input longint unsigned c,
                                              input longint unsigned len);
    longint unsigned u;
    u = 0;
    if (len != 0) u = (c * nccl_pkg::Q15_ONE + (len >> 1)) / len;
    if (u > nccl_pkg::Q15_ONE) u = nccl_pkg::Q15_ONE;
    return nccl_pkg::unit_t'(u);
  endfunction

  function automatic void normalise_centroid(input logic [nccl_pkg::SLOT_W-1:0] s,
                                             input logic [nccl_pkg::COMP_W-1:0] r,
                                             input logic [nccl_pkg::COMP_W-1:0] g,
                                             input logic [nccl_pkg::COMP_W-1:0] b);
    longint unsigned len;
    len = floor_sqrt(longint'(r) * r + longint'(g) * g + longint'(b) * b);
    unit_red[s]   = to_unit(r, len);
    unit_green[s] = to_unit(g, len);
    unit_blue[s]  = to_unit(b, len);
  endfunction

  // Largest dot product over the searched slots; strict compare keeps ties low.
  function automatic match_t nearest_centroid(input logic [nccl_pkg::PIX_W-1:0] r,
                                              input logic [nccl_pkg::PIX_W-1:0] g,
                                              input logic [nccl_pkg::PIX_W-1:0] b);
    match_t          m;
    int unsigned     count;
    longint unsigned dot;
    longint unsigned best;
    count = (search_count == 0) ? 1 : search_count;
    if (count > NUM_SLOTS) count = NUM_SLOTS;
    best    = 0;
    m.label = '0;
    for (int k = 0; k < count; k++) begin
      dot = longint'(r) * unit_red[k] + longint'(g) * unit_green[k]
          + longint'(b) * unit_blue[k];
      if (k == 0 || dot > best) begin
        best    = dot;
        m.label = nccl_pkg::LABEL_W'(k);
      end
    end
    m.similarity = nccl_pkg::DOT_W'(best);
    return m;
  endfunction

  // Send one word. Called just after a rising edge; returns just after the edge
  // that accepted the word with valid still high, or after the gap with valid low if one was taken.
  task automatic send_word(input logic cmd, input logic [nccl_pkg::SLOT_W-1:0] s,
                           input logic [nccl_pkg::COMP_W-1:0] cr,
                           input logic [nccl_pkg::COMP_W-1:0] cg,
                           input logic [nccl_pkg::COMP_W-1:0] cb,
                           input logic [nccl_pkg::PIX_W-1:0] pr,
                           input logic [nccl_pkg::PIX_W-1:0] pg,
                           input logic [nccl_pkg::PIX_W-1:0] pb);
    int unsigned gap;
    valid_i          <= 1'b1;
    cmd_i            <= cmd;
    slot_i           <= s;
    centroid_red_i   <= cr;
    centroid_green_i <= cg;
    centroid_blue_i  <= cb;
    pixel_red_i      <= pr;
    pixel_green_i    <= pg;
    pixel_blue_i     <= pb;
    // hold the word until the block takes it
    do @(posedge clk_i); while (stall_o);
    if (cmd == nccl_pkg::CMD_PIXEL) begin
      pending_matches.push_back(nearest_centroid(pr, pg, pb));
      pixels_sent++;
    end else begin
      normalise_centroid(s, cr, cg, cb);
      loads_sent++;
    end
    // bursts of random length, then usually a random gap with valid low
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_pixel(input logic [nccl_pkg::PIX_W-1:0] r,
                            input logic [nccl_pkg::PIX_W-1:0] g,
                            input logic [nccl_pkg::PIX_W-1:0] b);
    send_word(nccl_pkg::CMD_PIXEL, nccl_pkg::SLOT_W'($urandom),
              nccl_pkg::COMP_W'($urandom), nccl_pkg::COMP_W'($urandom),
              nccl_pkg::COMP_W'($urandom), r, g, b);
  endtask

  task automatic send_load(input logic [nccl_pkg::SLOT_W-1:0] s,
                           input logic [nccl_pkg::COMP_W-1:0] r,
                           input logic [nccl_pkg::COMP_W-1:0] g,
                           input logic [nccl_pkg::COMP_W-1:0] b);
    send_word(nccl_pkg::CMD_LOAD, s, r, g, b, nccl_pkg::PIX_W'($urandom),
              nccl_pkg::PIX_W'($urandom), nccl_pkg::PIX_W'($urandom));
  endtask

  // Drop valid and wait until every pixel has come back and any load has settled.
  task automatic drain_to_idle();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (LOAD_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_search_count(input logic [nccl_pkg::CFG_W-1:0] value);
    drain_to_idle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    search_count  = value;
  endtask

  function automatic logic [nccl_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return nccl_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [nccl_pkg::COMP_W-1:0] rand_component();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return nccl_pkg::COMP_W'($urandom_range(0, 255));
      default: return nccl_pkg::COMP_W'($urandom);
    endcase
  endfunction

  // Fill every slot first so no search can touch an unwritten slot, then hit
  // the corner colours, the black pixel, the zero centroid and a tie.
  task automatic test_directed();
    send_load(0, 0, 0, 0);                 // zero centroid: cosine 0 everywhere
    send_load(1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_load(2, 16'hFFFF, 0, 0);
    send_load(3, 0, 16'hFFFF, 0);
    send_load(4, 0, 0, 16'hFFFF);
    send_load(5, 1, 0, 0);                 // same direction as slot 2: a tie
    send_load(6, 1, 1, 1);
    for (int s = 7; s < NUM_SLOTS; s++)
      send_load(nccl_pkg::SLOT_W'(s), rand_component(), rand_component(),
                rand_component());
    write_search_count(16);
    send_pixel(0, 0, 0);                   // black pixel
    send_pixel(255, 255, 255);
    send_pixel(255, 0, 0);                 // tie between slots 2 and 5
    send_pixel(0, 255, 0);
    send_pixel(0, 0, 255);
    send_pixel(1, 2, 3);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h55, 8'hAA, 8'h55);
  endtask

  // Walk the count through its extremes, zero and the saturating values among them.
  task automatic test_count_sweep();
    logic [nccl_pkg::CFG_W-1:0] sweep [7] = '{0, 1, 31, 17, 16, 2, 15};
    foreach (sweep[i]) begin
      write_search_count(sweep[i]);
      for (int n = 0; n < 20; n++) begin
        if ($urandom_range(0, 9) == 0)
          send_load(nccl_pkg::SLOT_W'($urandom), rand_component(), rand_component(),
                    rand_component());
        else
          send_pixel(rand_pixel(), rand_pixel(), rand_pixel());
      end
    end
  endtask

  task automatic test_random_stream(input int unsigned words);
    for (int n = 0; n < words; n++) begin
      if (n % 150 == 149)
        write_search_count(nccl_pkg::CFG_W'($urandom_range(0, 31)));
      if (n == words / 2)
        drain_to_idle();                   // sender holds off until all results are back
      if ($urandom_range(0, 99) < 12)
        send_load(nccl_pkg::SLOT_W'($urandom), rand_component(), rand_component(),
                  rand_component());
      else
        send_pixel(rand_pixel(), rand_pixel(), rand_pixel());
    end
  endtask

  // Receiver stall: rotate through four patterns in turn.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_i     <= 1'b0;
      stall_cycle <= 0;
    end else begin
      stall_cycle <= stall_cycle + 1;
      case (stall_cycle[9:8])
        2'd0:    stall_i <= 1'b0;
        2'd1:    stall_i <= ($urandom_range(0, 3) == 0);
        2'd2:    stall_i <= (stall_cycle[2:0] < 3);
        2'd3:    stall_i <= ($urandom_range(0, 2) != 0);
        default: stall_i <= 1'b0;
      endcase
    end
  end

  // Check every accepted output word against the oldest pending answer.
  always @(posedge clk_i) begin
    match_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_matches.size() == 0) begin
        $display("%0t: expected no word, actual label %0d similarity %0d",
                 $time, label_o, similarity_o);
        errors++;
      end else begin
        want = pending_matches.pop_front();
        labels_checked++;
        if (label_o !== want.label) begin
          $display("%0t: label expected %0d actual %0d", $time, want.label, label_o);
          errors++;
        end
        if (similarity_o !== want.similarity) begin
          $display("%0t: similarity expected %0d actual %0d",
                   $time, want.similarity, similarity_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("%0t: run timed out", $time);
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_data_i       = '0;
    valid_i          = 1'b0;
    cmd_i            = nccl_pkg::CMD_PIXEL;
    slot_i           = '0;
    centroid_red_i   = '0;
    centroid_green_i = '0;
    centroid_blue_i  = '0;
    pixel_red_i      = '0;
    pixel_green_i    = '0;
    pixel_blue_i     = '0;
    errors           = 0;
    pixels_sent      = 0;
    loads_sent       = 0;
    labels_checked   = 0;
    burst_left       = 0;
    search_count     = 1;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      unit_red[s]   = '0;
      unit_green[s] = '0;
      unit_blue[s]  = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_count_sweep();
    test_random_stream(590);

    drain_to_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d pixel words and %0d centroid loads, %0d labels checked,",
             pixels_sent, loads_sent, labels_checked);
    $display("over search counts from 0 to 31 with bursty input and output stalls.");
    if (errors == 0 && pending_matches.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
sv/nccl_pkg.sv
sv/nccl_norm.sv
sv/nccl_argmax.sv
sv/nearest_chroma_classifier_unit.sv
test/testbench.sv
